// ----- src/corner_interp_tile_max_finder_core_defines.svh -----
`ifndef CORNER_INTERP_TILE_MAX_FINDER_CORE_DEFINES_SVH
`define CORNER_INTERP_TILE_MAX_FINDER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define CIT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define CIT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cit_pkg.sv -----
`default_nettype none

package cit_pkg;

    localparam int READING_W  = 10;
    localparam int TILE_IDX_W = 5;
    localparam int CENTER_W   = 9;
    localparam int BEST_SUM_W = 18;

    typedef struct packed {
        logic [READING_W-1:0] corner_top_left;
        logic [READING_W-1:0] corner_top_right;
        logic [READING_W-1:0] corner_bottom_left;
        logic [READING_W-1:0] corner_bottom_right;
    } corners_t;

    typedef struct packed {
        logic                  found;
        logic [TILE_IDX_W-1:0] best_tile_row;
        logic [TILE_IDX_W-1:0] best_tile_col;
        logic [CENTER_W-1:0]   center_row;
        logic [CENTER_W-1:0]   center_col;
        logic [BEST_SUM_W-1:0] best_sum;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic issue;
        logic tile_last;
        logic item_last;
        logic load_out;
    } cmd_t;

endpackage

`default_nettype wire

// ----- src/cit_cdiv.sv -----
`default_nettype none

module cit_cdiv #(
    parameter int XW  = 19,
    parameter int DIV = 300,
    parameter int QW  = 10
) (
    input  logic          clk,
    input  logic [XW-1:0] x,
    output logic [QW-1:0] q
);

    // The reciprocal estimate is never above the true quotient and at most one
    // below it, since x stays under 2^XW; one compare and add fixes it.
    localparam logic [XW:0]   POW   = {1'b1, {XW{1'b0}}};
    localparam logic [XW-1:0] RECIP = XW'(POW / (XW+1)'(DIV));
    localparam logic [XW-1:0] DIV_V = XW'(DIV);

    logic [2*XW-1:0] prod;
    logic [XW-1:0]   x_reg;
    logic [QW-1:0]   est_reg;
    logic [QW-1:0]   est_next;
    logic [XW-1:0]   rem;
    logic [QW-1:0]   q_reg;
    logic [QW-1:0]   q_next;

    assign prod     = (2*XW)'(x) * (2*XW)'(RECIP);
    assign est_next = QW'(prod[2*XW-1:XW]);

    assign rem    = x_reg - XW'(est_reg) * DIV_V;
    assign q_next = (rem >= DIV_V) ? est_reg + QW'(1) : est_reg;

    always_ff @(posedge clk)
    begin
        x_reg   <= x;
        est_reg <= est_next;
        q_reg   <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

// ----- src/cit_ctrl.sv -----
`default_nettype none
`include "corner_interp_tile_max_finder_core_defines.svh"

module cit_ctrl #(
    parameter int MAP_EDGE  = 300,
    parameter int TILE_EDGE = 12,
    localparam int MW = $clog2(MAP_EDGE)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          corner_valid,
    output logic          corner_stall,
    output logic          result_valid,
    input  logic          result_stall,
    input  logic          done,
    output cit_pkg::cmd_t cmd,
    output logic [MW-1:0] row,
    output logic [MW-1:0] col,
    output logic [MW-1:0] ti,
    output logic [MW-1:0] tj
);

    import cit_pkg::*;

    localparam int NT = MAP_EDGE / TILE_EDGE;
    localparam int TW = $clog2(TILE_EDGE + 1);
    localparam logic HAS_TILES = (NT > 0);
    localparam logic [TW-1:0] T_LAST  = TW'(TILE_EDGE - 1);
    localparam logic [MW-1:0] NT_LAST = MW'(NT - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]    state_reg,    state_next;
    logic [TW-1:0] cc_reg,       cc_next;
    logic [TW-1:0] rr_reg,       rr_next;
    logic [MW-1:0] tj_reg,       tj_next;
    logic [MW-1:0] ti_reg,       ti_next;
    logic [MW-1:0] row_reg,      row_next;
    logic [MW-1:0] col_reg,      col_next;
    logic [MW-1:0] row_base_reg, row_base_next;
    logic [MW-1:0] col_base_reg, col_base_next;
    logic          out_valid_reg, out_valid_next;

    logic          tile_last;
    logic          item_last;
    logic          load_out;
    logic [MW-1:0] row_step;
    logic [MW-1:0] col_step;

    assign tile_last = (cc_reg == T_LAST) && (rr_reg == T_LAST);
    assign item_last = tile_last && (tj_reg == NT_LAST) && (ti_reg == NT_LAST);
    assign load_out  = (state_reg == ST_FIN) && (!out_valid_reg || !result_stall);
    assign row_step  = MW'((MW+1)'(row_base_reg) + (MW+1)'(TILE_EDGE));
    assign col_step  = MW'((MW+1)'(col_base_reg) + (MW+1)'(TILE_EDGE));

    always_comb
    begin
        cmd.start     = corner_valid && (state_reg == ST_IDLE);
        cmd.issue     = (state_reg == ST_RUN);
        cmd.tile_last = tile_last;
        cmd.item_last = item_last;
        cmd.load_out  = load_out;
    end

    always_comb
    begin
        state_next    = state_reg;
        cc_next       = cc_reg;
        rr_next       = rr_reg;
        tj_next       = tj_reg;
        ti_next       = ti_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        row_base_next = row_base_reg;
        col_base_next = col_base_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cc_next       = '0;
                rr_next       = '0;
                tj_next       = '0;
                ti_next       = '0;
                row_next      = '0;
                col_next      = '0;
                row_base_next = '0;
                col_base_next = '0;
                if (corner_valid)
                begin
                    state_next = HAS_TILES ? ST_RUN : ST_FIN;
                end
            end
            ST_RUN:
            begin
                // Cells go out tile by tile, row-major inside each tile.
                if (cc_reg != T_LAST)
                begin
                    cc_next  = cc_reg + TW'(1);
                    col_next = col_reg + MW'(1);
                end
                else
                begin
                    cc_next = '0;
                    if (rr_reg != T_LAST)
                    begin
                        rr_next  = rr_reg + TW'(1);
                        row_next = row_reg + MW'(1);
                        col_next = col_base_reg;
                    end
                    else
                    begin
                        rr_next = '0;
                        if (tj_reg != NT_LAST)
                        begin
                            tj_next       = tj_reg + MW'(1);
                            col_base_next = col_step;
                            col_next      = col_step;
                            row_next      = row_base_reg;
                        end
                        else
                        begin
                            tj_next       = '0;
                            col_base_next = '0;
                            col_next      = '0;
                            if (ti_reg != NT_LAST)
                            begin
                                ti_next       = ti_reg + MW'(1);
                                row_base_next = row_step;
                                row_next      = row_step;
                            end
                            else
                            begin
                                ti_next       = '0;
                                row_base_next = '0;
                                row_next      = '0;
                                state_next    = ST_DRAIN;
                            end
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cc_reg        <= '0;
            rr_reg        <= '0;
            tj_reg        <= '0;
            ti_reg        <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            row_base_reg  <= '0;
            col_base_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cc_reg        <= cc_next;
            rr_reg        <= rr_next;
            tj_reg        <= tj_next;
            ti_reg        <= ti_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            row_base_reg  <= row_base_next;
            col_base_reg  <= col_base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign corner_stall = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign row          = row_reg;
    assign col          = col_reg;
    assign ti           = ti_reg;
    assign tj           = tj_reg;

    `CIT_ASSERT_IMP(a_done_in_drain, done, state_reg == ST_DRAIN, "map completion outside drain")
    `CIT_ASSERT_NXT(a_last_cell_ends_run, cmd.issue && cmd.item_last, !cmd.issue, "cell after last")
    `CIT_ASSERT_NXT(a_first_cell_at_origin, cmd.start,
        row == '0 && col == '0 && ti == '0 && tj == '0, "first cell not at map origin")

endmodule

`default_nettype wire

// ----- src/cit_datapath.sv -----
`default_nettype none

module cit_datapath #(
    parameter int MAP_EDGE  = 300,
    parameter int TILE_EDGE = 12,
    localparam int MW = $clog2(MAP_EDGE)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cit_pkg::cmd_t     cmd,
    input  logic [MW-1:0]     row,
    input  logic [MW-1:0]     col,
    input  logic [MW-1:0]     ti,
    input  logic [MW-1:0]     tj,
    input  cit_pkg::corners_t corners,
    output logic              done,
    output cit_pkg::result_t  result
);

    import cit_pkg::*;

    localparam int CELL_W = READING_W + 1;
    localparam int NUMW   = READING_W + MW;
    localparam int WW     = 2 * MW + 2;
    localparam int PW     = READING_W + WW;
    localparam int SUMW   = CELL_W + 2 * $clog2(TILE_EDGE + 1);
    localparam int QSW    = 2 * MW + 4;
    localparam int DEPTH  = 9;
    localparam int H2     = MAP_EDGE / 2;
    localparam int HALF   = (TILE_EDGE + 1) / 2;

    localparam logic [MW-1:0]         EDGE_LAST = MW'(MAP_EDGE - 1);
    localparam logic [WW-1:0]         NSQ       = WW'(MAP_EDGE * MAP_EDGE);
    localparam logic signed [QSW-1:0] ONE_S     = 1;
    localparam logic [31:0] TILE_IDX_MAX = 32'((1 << TILE_IDX_W) - 1);
    localparam logic [31:0] CENTER_MAX   = 32'((1 << CENTER_W) - 1);
    localparam logic [31:0] BEST_MAX     = 32'((1 << BEST_SUM_W) - 1);

    typedef struct packed {
        logic          valid;
        logic          tile_last;
        logic          item_last;
        logic          c_last;
        logic [MW-1:0] row;
        logic [MW-1:0] ti;
        logic [MW-1:0] tj;
    } side_t;

    // lo*N + (hi-lo)*pos, which equals lo*(N-pos) + hi*pos and is never negative.
    function automatic logic [NUMW-1:0] interp_num(input logic [READING_W-1:0] lo,
                                                   input logic [READING_W-1:0] hi,
                                                   input logic [MW-1:0] pos);
        logic signed [NUMW+1:0] base_s;
        logic signed [NUMW+1:0] diff_s;
        logic signed [NUMW+1:0] pos_s;
        logic signed [NUMW+1:0] sum_s;
        base_s = signed'((NUMW+2)'(lo) * (NUMW+2)'(MAP_EDGE));
        diff_s = signed'((NUMW+2)'(hi)) - signed'((NUMW+2)'(lo));
        pos_s  = signed'((NUMW+2)'(pos));
        sum_s  = base_s + diff_s * pos_s;
        return NUMW'(sum_s);
    endfunction

    // (pos-(N/2-1))*(pos-N/2) written as a*(a+1) with a = pos-N/2.
    function automatic logic [WW-1:0] qterm(input logic [MW-1:0] pos);
        logic signed [QSW-1:0] a_s;
        logic signed [QSW-1:0] p_s;
        a_s = signed'(QSW'(pos)) - signed'(QSW'(H2));
        p_s = a_s * (a_s + ONE_S);
        return WW'(p_s);
    endfunction

    function automatic logic [31:0] sat_to(input logic [31:0] v, input logic [31:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    side_t             side_in;
    side_t             side_reg [1:DEPTH];
    corners_t          corners_reg;

    logic [NUMW-1:0]   topn_reg, topn_next;
    logic [NUMW-1:0]   botn_reg, botn_next;
    logic [WW-1:0]     qa_reg,   qa_next;
    logic [WW-1:0]     qb_reg,   qb_next;
    logic [WW-1:0]     w_reg [2:6];
    logic [WW-1:0]     w_next;

    logic [READING_W-1:0] top_q, bot_q, top_v, bot_v;
    logic [NUMW-1:0]   vn_reg, vn_next;
    logic [READING_W-1:0] bot_reg [4:6];
    logic [READING_W-1:0] v_q, v_sel;
    logic [PW-1:0]     p_reg, p_next;
    logic [CELL_W-1:0] wt_cell;

    logic [SUMW-1:0]   tile_sum;
    logic [SUMW-1:0]   acc_reg,  acc_next;
    logic [SUMW-1:0]   best_reg, best_next;
    logic [MW-1:0]     bti_reg,  bti_next;
    logic [MW-1:0]     btj_reg,  btj_next;
    logic              done_reg, done_next;

    logic [31:0]       row1, col1, crow, ccol;
    logic [31:0]       row_s, col_s, crow_s, ccol_s, bsum_s;
    result_t           result_reg, result_next;

    // Stage 1: edge-row numerators and the two halves of the weight term.
    always_comb
    begin
        side_in.valid     = cmd.issue;
        side_in.tile_last = cmd.tile_last;
        side_in.item_last = cmd.item_last;
        side_in.c_last    = (col == EDGE_LAST);
        side_in.row       = row;
        side_in.ti        = ti;
        side_in.tj        = tj;
        topn_next = interp_num(corners_reg.corner_top_left, corners_reg.corner_top_right, col);
        botn_next = interp_num(corners_reg.corner_bottom_left,
                               corners_reg.corner_bottom_right, col);
        qa_next   = qterm(row);
        qb_next   = qterm(col);
        w_next    = ((qa_reg + qb_reg) << 1) + NSQ;
    end

    cit_cdiv #(.XW(NUMW), .DIV(MAP_EDGE), .QW(READING_W)) u_div_top (
        .clk (clk),
        .x   (topn_reg),
        .q   (top_q)
    );

    cit_cdiv #(.XW(NUMW), .DIV(MAP_EDGE), .QW(READING_W)) u_div_bot (
        .clk (clk),
        .x   (botn_reg),
        .q   (bot_q)
    );

    // Stage 3 out: the last column keeps the right-hand corners exactly.
    always_comb
    begin
        top_v   = side_reg[3].c_last ? corners_reg.corner_top_right : top_q;
        bot_v   = side_reg[3].c_last ? corners_reg.corner_bottom_right : bot_q;
        vn_next = interp_num(top_v, bot_v, side_reg[3].row);
    end

    cit_cdiv #(.XW(NUMW), .DIV(MAP_EDGE), .QW(READING_W)) u_div_col (
        .clk (clk),
        .x   (vn_reg),
        .q   (v_q)
    );

    // Stage 6 out: the bottom row takes the edge value unchanged.
    always_comb
    begin
        v_sel  = (side_reg[6].row == EDGE_LAST) ? bot_reg[6] : v_q;
        p_next = PW'(v_sel) * PW'(w_reg[6]);
    end

    cit_cdiv #(.XW(PW), .DIV(2 * MAP_EDGE * MAP_EDGE), .QW(CELL_W)) u_div_wt (
        .clk (clk),
        .x   (p_reg),
        .q   (wt_cell)
    );

    // Stage 10: tile accumulation and running maximum; ties keep the earlier tile.
    assign tile_sum = acc_reg + SUMW'(wt_cell);

    always_comb
    begin
        acc_next  = acc_reg;
        best_next = best_reg;
        bti_next  = bti_reg;
        btj_next  = btj_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            acc_next  = '0;
            best_next = '0;
            bti_next  = '0;
            btj_next  = '0;
        end
        else if (side_reg[DEPTH].valid)
        begin
            done_next = side_reg[DEPTH].item_last;
            if (side_reg[DEPTH].tile_last)
            begin
                acc_next = '0;
                if (tile_sum > best_reg)
                begin
                    best_next = tile_sum;
                    bti_next  = side_reg[DEPTH].ti;
                    btj_next  = side_reg[DEPTH].tj;
                end
            end
            else
            begin
                acc_next = tile_sum;
            end
        end
    end

    always_comb
    begin
        row1   = 32'(bti_reg) + 32'd1;
        col1   = 32'(btj_reg) + 32'd1;
        crow   = row1 * 32'(TILE_EDGE) - 32'(HALF);
        ccol   = col1 * 32'(TILE_EDGE) - 32'(HALF);
        row_s  = sat_to(row1, TILE_IDX_MAX);
        col_s  = sat_to(col1, TILE_IDX_MAX);
        crow_s = sat_to(crow, CENTER_MAX);
        ccol_s = sat_to(ccol, CENTER_MAX);
        bsum_s = sat_to(32'(best_reg), BEST_MAX);
        result_next = '0;
        if (best_reg != '0)
        begin
            result_next.found         = 1'b1;
            result_next.best_tile_row = row_s[TILE_IDX_W-1:0];
            result_next.best_tile_col = col_s[TILE_IDX_W-1:0];
            result_next.center_row    = crow_s[CENTER_W-1:0];
            result_next.center_col    = ccol_s[CENTER_W-1:0];
            result_next.best_sum      = bsum_s[BEST_SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= DEPTH; k++)
            begin
                side_reg[k] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            side_reg[1] <= side_in;
            for (int k = 2; k <= DEPTH; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            corners_reg <= corners;
        end
        if (cmd.load_out)
        begin
            result_reg <= result_next;
        end
        topn_reg <= topn_next;
        botn_reg <= botn_next;
        qa_reg   <= qa_next;
        qb_reg   <= qb_next;
        w_reg[2] <= w_next;
        for (int k = 3; k <= 6; k++)
        begin
            w_reg[k] <= w_reg[k-1];
        end
        vn_reg     <= vn_next;
        bot_reg[4] <= bot_v;
        bot_reg[5] <= bot_reg[4];
        bot_reg[6] <= bot_reg[5];
        p_reg      <= p_next;
        acc_reg    <= acc_next;
        best_reg   <= best_next;
        bti_reg    <= bti_next;
        btj_reg    <= btj_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- src/corner_interp_tile_max_finder_core.sv -----
// Each accepted corner word yields one result word once the map's C cells are processed, where
// C = ((MAP_EDGE/TILE_EDGE)*TILE_EDGE)^2 cells in whole tiles (90000 at defaults).
// Throughput: one corner word at a time; the cell sequencer feeds one cell per cycle
// into a 10-stage weighting pipeline, and a waiting result word does not block the next input.
// Reset: rst_n (asynchronous, active low) clears the controller, pipeline valid flags and
// the result valid; no memory needs clearing.
`default_nettype none

module corner_interp_tile_max_finder_core #(
    parameter int MAP_EDGE  = 300,
    parameter int TILE_EDGE = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              corner_valid,
    output logic              corner_stall,
    input  cit_pkg::corners_t corners,
    output logic              result_valid,
    input  logic              result_stall,
    output cit_pkg::result_t  result
);

    import cit_pkg::*;

    localparam int MW = $clog2(MAP_EDGE);

    cmd_t          cmd;
    logic          done;
    logic [MW-1:0] row;
    logic [MW-1:0] col;
    logic [MW-1:0] ti;
    logic [MW-1:0] tj;

    cit_ctrl #(.MAP_EDGE(MAP_EDGE), .TILE_EDGE(TILE_EDGE)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .corner_valid (corner_valid),
        .corner_stall (corner_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .done         (done),
        .cmd          (cmd),
        .row          (row),
        .col          (col),
        .ti           (ti),
        .tj           (tj)
    );

    cit_datapath #(.MAP_EDGE(MAP_EDGE), .TILE_EDGE(TILE_EDGE)) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .row     (row),
        .col     (col),
        .ti      (ti),
        .tj      (tj),
        .corners (corners),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire
